@@ design/process_table_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
// Both forms sample on clk_i and are disabled while rst_ni is low.
`ifndef PROCESS_TABLE_SCHEDULER_DEFINES_SVH
`define PROCESS_TABLE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTS_ASSERT_IMP(lbl, ante, cons, msg)
`define PTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/pts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // Table geometry
  localparam int SLOTS = 16;
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);

  typedef logic [SlotW-1:0] slot_idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam slot_idx_t LastIdx  = slot_idx_t'(SLOTS - 1);
  localparam cnt_t      SlotsCnt = cnt_t'(SLOTS);

  // Arithmetic constants
  localparam logic signed [7:0] PrioBase   = 8'sd100;
  localparam logic signed [7:0] PrioMin    = 8'sh80;
  localparam logic [6:0]        ElapsedMax = 7'd127;

  // Configuration register indexes
  typedef enum logic {
    CFG_POLICY_MODE = 1'b0,
    CFG_READY_LIMIT = 1'b1
  } cfg_idx_e;

  // Input transaction kind
  typedef enum logic {
    KIND_CREATE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  // Per-slot process state
  typedef enum logic [2:0] {
    ST_EMPTY  = 3'd0,
    ST_READY  = 3'd1,
    ST_WAIT   = 3'd2,
    ST_FINISH = 3'd3
  } slot_state_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CREATE,
    SEQ_CHECK,
    SEQ_SCAN_SEL,
    SEQ_RUN,
    SEQ_SCAN_NEXT,
    SEQ_FINISH,
    SEQ_EMIT
  } seq_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] need_time;
  } pts_in_t;

  typedef struct packed {
    logic [3:0]        slot;
    logic              refused;
    logic              started_waiting;
    logic              ran;
    logic [6:0]        remaining;
    logic [6:0]        elapsed;
    logic signed [7:0] prio;
    logic              finished;
    logic [3:0]        next_slot;
    logic              next_valid;
    logic              done_res;
  } pts_out_t;

  typedef struct packed {
    slot_state_e       state;
    logic signed [7:0] prio;
    logic [6:0]        remaining;
    logic [6:0]        elapsed;
  } pts_entry_t;

  typedef struct packed {
    logic       en;
    logic       state_only;
    slot_idx_t  addr;
    pts_entry_t data;
  } pts_wr_t;

  // Low four bits of a slot index, zero-extended for small tables
  function automatic logic [3:0] slot4(slot_idx_t idx);
    logic [SlotW+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

  // Created count below the ready limit
  function automatic logic below_limit(cnt_t cnt, logic [4:0] limit);
    logic [7:0] a;
    logic [7:0] b;
    a = 8'(cnt);
    b = 8'(limit);
    return a < b;
  endfunction

endpackage

`default_nettype wire

@@ design/pts_slot_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pts_slot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  pts_pkg::slot_idx_t  rd_addr_i,
  output pts_pkg::pts_entry_t rd_data_o,
  input  pts_pkg::pts_wr_t    wr_i
);

  pts_pkg::slot_state_e state_q [pts_pkg::SLOTS];
  logic signed [7:0]    prio_q  [pts_pkg::SLOTS];
  logic [6:0]           rem_q   [pts_pkg::SLOTS];
  logic [6:0]           el_q    [pts_pkg::SLOTS];

  // Hold slot states; clear drops every slot back to empty at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pts_pkg::SLOTS; i++) begin
        state_q[i] <= pts_pkg::ST_EMPTY;
      end
    end else if (clear_i) begin
      for (int i = 0; i < pts_pkg::SLOTS; i++) begin
        state_q[i] <= pts_pkg::ST_EMPTY;
      end
    end else if (wr_i.en) begin
      state_q[wr_i.addr] <= wr_i.data.state;
    end
  end

  // Payload fields are only meaningful for non-empty slots
  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.state_only) begin
      prio_q[wr_i.addr] <= wr_i.data.prio;
      rem_q[wr_i.addr]  <= wr_i.data.remaining;
      el_q[wr_i.addr]   <= wr_i.data.elapsed;
    end
  end

  // Single read port
  always_comb begin
    rd_data_o.state     = state_q[rd_addr_i];
    rd_data_o.prio      = prio_q[rd_addr_i];
    rd_data_o.remaining = rem_q[rd_addr_i];
    rd_data_o.elapsed   = el_q[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ design/pts_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "process_table_scheduler_defines.svh"

module pts_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pts_pkg::pts_in_t    item_i,
  input  logic                policy_mode_i,
  input  logic [4:0]          ready_limit_i,
  output logic                idle_o,
  input  logic                out_free_i,
  output logic                push_o,
  output pts_pkg::pts_out_t   res_o,
  output logic                tbl_clear_o,
  output pts_pkg::slot_idx_t  tbl_addr_o,
  input  pts_pkg::pts_entry_t tbl_rd_i,
  output pts_pkg::pts_wr_t    tbl_wr_o
);

  pts_pkg::seq_state_e state_q, state_d;

  logic [6:0]          need_q;
  pts_pkg::cnt_t       cnt_q;
  pts_pkg::slot_idx_t  cur_q;
  logic                cur_valid_q;
  pts_pkg::slot_idx_t  idx_q;
  pts_pkg::slot_idx_t  q_q;
  logic                fin_q;
  logic                a_found_q;
  pts_pkg::slot_idx_t  a_idx_q;
  logic signed [7:0]   a_prio_q;
  logic                b_found_q;
  pts_pkg::slot_idx_t  b_idx_q;
  logic                w_found_q;
  pts_pkg::slot_idx_t  w_idx_q;
  pts_pkg::pts_out_t   res_q;

  // Run arithmetic on the selected slot
  logic [6:0]        rem_n;
  logic [6:0]        el_n;
  logic signed [7:0] prio_dec;
  logic signed [7:0] prio_n;
  logic              fin_n;

  always_comb begin
    rem_n    = (tbl_rd_i.remaining != 7'd0) ? tbl_rd_i.remaining - 7'd1 : 7'd0;
    el_n     = (tbl_rd_i.elapsed != pts_pkg::ElapsedMax) ? tbl_rd_i.elapsed + 7'd1
                                                          : pts_pkg::ElapsedMax;
    prio_dec = (policy_mode_i && (tbl_rd_i.prio != pts_pkg::PrioMin))
               ? tbl_rd_i.prio - 8'sd1 : tbl_rd_i.prio;
    fin_n    = (rem_n == 7'd0);
    prio_n   = fin_n ? 8'sd0 : prio_dec;
  end

  // Shared scan compare: one slot per cycle
  logic last;
  logic wait_hit;
  logic eff_ready;
  logic a_filter;
  logic a_take;
  logic b_take;

  always_comb begin
    last      = (idx_q == pts_pkg::LastIdx);
    wait_hit  = (state_q == pts_pkg::SEQ_SCAN_NEXT) && fin_q &&
                (tbl_rd_i.state == pts_pkg::ST_WAIT) && !w_found_q;
    eff_ready = (tbl_rd_i.state == pts_pkg::ST_READY) || wait_hit;
    if (state_q == pts_pkg::SEQ_SCAN_NEXT) begin
      a_filter = policy_mode_i ? (idx_q != q_q) : (idx_q > q_q);
    end else begin
      a_filter = 1'b1;
    end
    a_take = eff_ready && a_filter &&
             (!a_found_q || (policy_mode_i && (tbl_rd_i.prio > a_prio_q)));
    b_take = eff_ready && !b_found_q;
  end

  // Next-slot decision after the post-run scan
  logic               next_ok;
  pts_pkg::slot_idx_t next_idx;

  always_comb begin
    next_ok  = 1'b0;
    next_idx = q_q;
    if (policy_mode_i) begin
      if (fin_q) begin
        next_ok  = a_found_q;
        next_idx = a_idx_q;
      end else begin
        next_ok = 1'b1;
        if (a_found_q && (a_prio_q > res_q.prio)) begin
          next_idx = a_idx_q;
        end
      end
    end else if (a_found_q) begin
      next_ok  = 1'b1;
      next_idx = a_idx_q;
    end else if (b_found_q) begin
      next_ok  = 1'b1;
      next_idx = b_idx_q;
    end
  end

  // Create result
  logic              table_full;
  logic              start_ready;
  pts_pkg::pts_out_t create_res;

  always_comb begin
    table_full  = (cnt_q >= pts_pkg::SlotsCnt);
    start_ready = pts_pkg::below_limit(cnt_q, ready_limit_i);
    create_res  = '0;
    if (table_full) begin
      create_res.refused = 1'b1;
    end else begin
      create_res.slot            = pts_pkg::slot4(cnt_q[pts_pkg::SlotW-1:0]);
      create_res.started_waiting = !start_ready;
    end
  end

  logic cur_hit;
  assign cur_hit = cur_valid_q && (tbl_rd_i.state == pts_pkg::ST_READY);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::SEQ_IDLE: begin
        if (start_i) begin
          state_d = (item_i.kind == pts_pkg::KIND_TICK) ? pts_pkg::SEQ_CHECK
                                                        : pts_pkg::SEQ_CREATE;
        end
      end
      pts_pkg::SEQ_CREATE:   state_d = pts_pkg::SEQ_EMIT;
      pts_pkg::SEQ_CHECK:    state_d = cur_hit ? pts_pkg::SEQ_RUN : pts_pkg::SEQ_SCAN_SEL;
      pts_pkg::SEQ_SCAN_SEL: begin
        if (last) begin
          state_d = (a_found_q || a_take) ? pts_pkg::SEQ_RUN : pts_pkg::SEQ_EMIT;
        end
      end
      pts_pkg::SEQ_RUN:       state_d = pts_pkg::SEQ_SCAN_NEXT;
      pts_pkg::SEQ_SCAN_NEXT: begin
        if (last) begin
          state_d = pts_pkg::SEQ_FINISH;
        end
      end
      pts_pkg::SEQ_FINISH:    state_d = pts_pkg::SEQ_EMIT;
      pts_pkg::SEQ_EMIT: begin
        if (out_free_i) begin
          state_d = pts_pkg::SEQ_IDLE;
        end
      end
      default:                state_d = pts_pkg::SEQ_IDLE;
    endcase
  end

  // Outputs: table port, clear and result push
  always_comb begin
    idle_o      = (state_q == pts_pkg::SEQ_IDLE);
    push_o      = (state_q == pts_pkg::SEQ_EMIT) && out_free_i;
    res_o       = res_q;
    tbl_clear_o = 1'b0;
    tbl_addr_o  = idx_q;
    tbl_wr_o    = '0;
    unique case (state_q)
      pts_pkg::SEQ_CREATE: begin
        tbl_wr_o.en                  = !table_full;
        tbl_wr_o.addr                = cnt_q[pts_pkg::SlotW-1:0];
        tbl_wr_o.data.state          = start_ready ? pts_pkg::ST_READY : pts_pkg::ST_WAIT;
        tbl_wr_o.data.prio           = pts_pkg::PrioBase - $signed({1'b0, need_q});
        tbl_wr_o.data.remaining      = need_q;
        tbl_wr_o.data.elapsed        = 7'd0;
      end
      pts_pkg::SEQ_CHECK: begin
        tbl_addr_o = cur_q;
      end
      pts_pkg::SEQ_SCAN_SEL: begin
        tbl_clear_o = last && !(a_found_q || a_take);
      end
      pts_pkg::SEQ_RUN: begin
        tbl_addr_o              = q_q;
        tbl_wr_o.en             = 1'b1;
        tbl_wr_o.addr           = q_q;
        tbl_wr_o.data.state     = fin_n ? pts_pkg::ST_FINISH : pts_pkg::ST_READY;
        tbl_wr_o.data.prio      = prio_n;
        tbl_wr_o.data.remaining = rem_n;
        tbl_wr_o.data.elapsed   = el_n;
      end
      pts_pkg::SEQ_FINISH: begin
        tbl_clear_o         = !next_ok;
        tbl_wr_o.en         = w_found_q;
        tbl_wr_o.state_only = 1'b1;
        tbl_wr_o.addr       = w_idx_q;
        tbl_wr_o.data.state = pts_pkg::ST_READY;
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::SEQ_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pts_pkg::SEQ_CREATE && !table_full) begin
        cnt_q <= cnt_q + pts_pkg::cnt_t'(1);
      end
      if (state_q == pts_pkg::SEQ_FINISH && next_ok) begin
        cur_q       <= next_idx;
        cur_valid_q <= 1'b1;
      end
      // Clear table bookkeeping together with the slot states
      if (tbl_clear_o) begin
        cnt_q       <= '0;
        cur_q       <= '0;
        cur_valid_q <= 1'b0;
      end
    end
  end

  // Work registers and result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pts_pkg::SEQ_IDLE: begin
        if (start_i) begin
          need_q <= item_i.need_time;
        end
      end
      pts_pkg::SEQ_CREATE: begin
        res_q <= create_res;
      end
      pts_pkg::SEQ_CHECK: begin
        res_q     <= '0;
        idx_q     <= '0;
        a_found_q <= 1'b0;
        q_q       <= cur_q;
      end
      pts_pkg::SEQ_SCAN_SEL: begin
        idx_q <= idx_q + pts_pkg::slot_idx_t'(1);
        if (a_take) begin
          a_found_q <= 1'b1;
          a_idx_q   <= idx_q;
          a_prio_q  <= tbl_rd_i.prio;
        end
        if (last) begin
          q_q            <= a_take ? idx_q : a_idx_q;
          res_q.done_res <= !(a_found_q || a_take);
        end
      end
      pts_pkg::SEQ_RUN: begin
        fin_q           <= fin_n;
        res_q.slot      <= pts_pkg::slot4(q_q);
        res_q.ran       <= 1'b1;
        res_q.remaining <= rem_n;
        res_q.elapsed   <= el_n;
        res_q.prio      <= prio_n;
        res_q.finished  <= fin_n;
        idx_q           <= '0;
        a_found_q       <= 1'b0;
        b_found_q       <= 1'b0;
        w_found_q       <= 1'b0;
      end
      pts_pkg::SEQ_SCAN_NEXT: begin
        idx_q <= idx_q + pts_pkg::slot_idx_t'(1);
        if (wait_hit) begin
          w_found_q <= 1'b1;
          w_idx_q   <= idx_q;
        end
        if (a_take) begin
          a_found_q <= 1'b1;
          a_idx_q   <= idx_q;
          a_prio_q  <= tbl_rd_i.prio;
        end
        if (b_take) begin
          b_found_q <= 1'b1;
          b_idx_q   <= idx_q;
        end
      end
      pts_pkg::SEQ_FINISH: begin
        if (next_ok) begin
          res_q.next_slot  <= pts_pkg::slot4(next_idx);
          res_q.next_valid <= 1'b1;
        end else begin
          res_q.done_res <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  `PTS_ASSERT_IMP(a_push_free, push_o, out_free_i, "result pushed into a full output stage")
  `PTS_ASSERT_NXT(a_push_idle, push_o, state_q == pts_pkg::SEQ_IDLE, "no return to idle")
  `PTS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= pts_pkg::SlotsCnt, "created count overflow")
  `PTS_ASSERT_IMP(a_fin_zero, push_o && res_q.finished, res_q.remaining == 7'd0, "finish with time left")
  `PTS_ASSERT_IMP(a_next_cur, push_o && res_q.next_valid, cur_valid_q, "next slot not kept")

endmodule

`default_nettype wire

@@ design/process_table_scheduler.sv @@
// Process table scheduler.
// Input channel (in_valid_i/in_ready_o/in_data_i): a create transaction stores a
// process in the next free slot; a tick transaction runs one ready slot for one
// timeslice. Every input transaction yields exactly one output transaction on
// out_valid_o/out_ready_i/out_data_o.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 policy
// mode, 1 ready limit) at the clock edge; write only while the block is idle.
// Sequence: a create stores the slot and then presents its result. A tick
// reads the current slot and, when it is still ready, runs it at once; else a
// selection scan picks a slot first, and when nothing is runnable the table is
// cleared and a done result is given. After a run a second scan picks the next
// slot. The slot scans read one table entry per cycle through a single read
// port and share one compare unit. One item is in flight at a time; in_ready_o
// is high in idle only, so the next transaction is taken once the result is
// loaded and the block is back in idle.
// Output: a one-entry output register holds the result; while the receiver
// stalls, the block may accept and process the next item but holds its result
// until the register frees up.
// Reset (rst_ni low, asynchronous): table empty, counters cleared, policy mode
// round robin, ready limit 3, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module process_table_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pts_pkg::pts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pts_pkg::pts_out_t out_data_o
);

  logic       policy_mode_q;
  logic [4:0] ready_limit_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_mode_q <= 1'b0;
      ready_limit_q <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (pts_pkg::cfg_idx_e'(cfg_idx_i))
        pts_pkg::CFG_POLICY_MODE: policy_mode_q <= cfg_data_i[0];
        pts_pkg::CFG_READY_LIMIT: ready_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic                idle;
  logic                start;
  logic                out_free;
  logic                push;
  pts_pkg::pts_out_t   res;
  logic                tbl_clear;
  pts_pkg::slot_idx_t  tbl_addr;
  pts_pkg::pts_entry_t tbl_rd;
  pts_pkg::pts_wr_t    tbl_wr;

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;

  pts_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .item_i        (in_data_i),
    .policy_mode_i (policy_mode_q),
    .ready_limit_i (ready_limit_q),
    .idle_o        (idle),
    .out_free_i    (out_free),
    .push_o        (push),
    .res_o         (res),
    .tbl_clear_o   (tbl_clear),
    .tbl_addr_o    (tbl_addr),
    .tbl_rd_i      (tbl_rd),
    .tbl_wr_o      (tbl_wr)
  );

  pts_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (tbl_clear),
    .rd_addr_i (tbl_addr),
    .rd_data_o (tbl_rd),
    .wr_i      (tbl_wr)
  );

  // Output register: load on push, drop when the transaction completes
  logic              out_valid_q;
  pts_pkg::pts_out_t out_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ tb/tb_process_table_scheduler.sv @@
`timescale 1ns / 1ps

import pts_pkg::*;

// Track the process table, predict each result and check what comes back.
class sched_scoreboard;
  logic        policy;
  logic [4:0]  limit;
  slot_state_e st [SLOTS];
  int          pri [SLOTS];
  int          rem [SLOTS];
  int          ela [SLOTS];
  int          n_created;
  int          cur;
  bit          cur_ok;
  pts_out_t    owed_results [$];
  int          errors;
  int          n_create;
  int          n_tick;
  int          n_refused;
  int          n_waiting;
  int          n_finished;
  int          n_cleared;
  int          n_switch;
  int          n_checked;

  function new();
    policy = 1'b0;
    limit  = 5'd3;
    clear_table();
  endfunction

  function void set_reg(cfg_idx_e idx, logic [4:0] value);
    if (idx == CFG_POLICY_MODE) begin
      policy = value[0];
    end else begin
      limit = value;
    end
  endfunction

  // Empty every slot; the registers are kept
  function void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      st[i]  = ST_EMPTY;
      pri[i] = 0;
      rem[i] = 0;
      ela[i] = 0;
    end
    n_created = 0;
    cur       = 0;
    cur_ok    = 1'b0;
  endfunction

  // Highest priority ready slot, lowest index among equals
  function int best_ready(int skip);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != skip && st[i] == ST_READY && (b < 0 || pri[i] > pri[b])) b = i;
    end
    return b;
  endfunction

  // First ready slot in cyclic order
  function int first_ready(int from);
    int i;
    for (int k = 0; k < SLOTS; k++) begin
      i = (from + k) % SLOTS;
      if (st[i] == ST_READY) return i;
    end
    return -1;
  endfunction

  function pts_out_t schedule_step(pts_in_t d);
    pts_out_t r;
    int       q;
    int       nxt;
    int       alt;
    bit       fin;
    r   = '0;
    fin = 1'b0;
    // Create: fill the next slot, ready or waiting by the limit
    if (d.kind == KIND_CREATE) begin
      n_create++;
      if (n_created >= SLOTS) begin
        n_refused++;
        r.refused = 1'b1;
        return r;
      end
      q      = n_created;
      rem[q] = int'(d.need_time);
      ela[q] = 0;
      pri[q] = 100 - int'(d.need_time);
      if (n_created < int'(limit)) begin
        st[q] = ST_READY;
      end else begin
        st[q] = ST_WAIT;
        r.started_waiting = 1'b1;
        n_waiting++;
      end
      n_created++;
      r.slot = 4'(q);
      return r;
    end
    // Tick: keep the current slot while ready, else choose afresh
    n_tick++;
    if (cur_ok && st[cur] == ST_READY) q = cur;
    else if (policy) q = best_ready(-1);
    else q = first_ready(0);
    if (q < 0) begin
      clear_table();
      n_cleared++;
      r.done_res = 1'b1;
      return r;
    end
    if (rem[q] > 0) rem[q]--;
    if (ela[q] < 127) ela[q]++;
    if (policy && pri[q] > -128) pri[q]--;
    // Finish and wake the lowest waiting slot
    if (rem[q] == 0) begin
      fin    = 1'b1;
      st[q]  = ST_FINISH;
      pri[q] = 0;
      n_finished++;
      for (int k = 0; k < SLOTS; k++) begin
        if (st[k] == ST_WAIT) begin
          st[k] = ST_READY;
          break;
        end
      end
    end
    r.slot      = 4'(q);
    r.ran       = 1'b1;
    r.remaining = 7'(rem[q]);
    r.elapsed   = 7'(ela[q]);
    r.prio      = 8'(pri[q]);
    r.finished  = fin;
    // Pick the slot for the next tick
    if (policy) begin
      if (fin) begin
        nxt = best_ready(-1);
      end else begin
        alt = best_ready(q);
        nxt = q;
        if (alt >= 0 && pri[q] < pri[alt]) begin
          nxt = alt;
          n_switch++;
        end
      end
    end else begin
      nxt = first_ready((q + 1) % SLOTS);
    end
    if (nxt < 0) begin
      clear_table();
      n_cleared++;
      r.done_res = 1'b1;
    end else begin
      cur          = nxt;
      cur_ok       = 1'b1;
      r.next_slot  = 4'(nxt);
      r.next_valid = 1'b1;
    end
    return r;
  endfunction

  function void note_input(pts_in_t d);
    owed_results.push_back(schedule_step(d));
  endfunction

  function void cmp(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function void check_result(pts_out_t got);
    pts_out_t want;
    if (owed_results.size() == 0) begin
      errors++;
      $error("result transaction with nothing outstanding: %h", got);
      return;
    end
    want = owed_results.pop_front();
    n_checked++;
    cmp("slot", 8'(want.slot), 8'(got.slot));
    cmp("refused", 8'(want.refused), 8'(got.refused));
    cmp("started_waiting", 8'(want.started_waiting), 8'(got.started_waiting));
    cmp("ran", 8'(want.ran), 8'(got.ran));
    cmp("remaining", 8'(want.remaining), 8'(got.remaining));
    cmp("elapsed", 8'(want.elapsed), 8'(got.elapsed));
    cmp("prio (8-bit two's complement)", want.prio, got.prio);
    cmp("finished", 8'(want.finished), 8'(got.finished));
    cmp("next_slot", 8'(want.next_slot), 8'(got.next_slot));
    cmp("next_valid", 8'(want.next_valid), 8'(got.next_valid));
    cmp("done_res", 8'(want.done_res), 8'(got.done_res));
  endfunction

  function int owed();
    return owed_results.size();
  endfunction

  function bit table_used();
    return n_created > 0;
  endfunction
endclass

module tb_process_table_scheduler;

  localparam int StallLimit = 1000;
  localparam int HoldCycles = 120;
  localparam int PhaseItems = 80;
  localparam int NumPhases  = 6;
  localparam bit         PolicyPlan [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic [4:0] LimitPlan  [NumPhases] = '{5'd1, 5'd16, 5'd16, 5'd1, 5'd5, 5'd7};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [4:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  pts_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  pts_out_t   out_data_o;

  sched_scoreboard sched;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int quiet_cycles = 0;
  int n_settings   = 1;

  process_table_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one input transaction and wait for it to be taken
  task automatic send_item(input pts_in_t d);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sched.note_input(d);
  endtask

  task automatic do_create(input logic [6:0] need);
    pts_in_t d;
    d.kind      = KIND_CREATE;
    d.need_time = need;
    send_item(d);
  endtask

  task automatic do_tick();
    pts_in_t d;
    d.kind      = KIND_TICK;
    d.need_time = 7'($urandom_range(0, 127));
    send_item(d);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every outstanding result has come back
  task automatic settle();
    while (sched.owed() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sched.set_reg(idx, value);
  endtask

  // Mostly short jobs, a few long ones
  function automatic logic [6:0] pick_need();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 7'($urandom_range(1, 3));
    if (r < 95) return 7'($urandom_range(4, 12));
    return 7'($urandom_range(13, 99));
  endfunction

  task automatic drain_table();
    while (sched.table_used()) do_tick();
  endtask

  // One burst: fill and run the table to completion, or noise, or a cut-short fill
  task automatic run_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    send_idle_on = ($urandom_range(0, 3) != 0);
    if (pick < 7) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
      repeat (n) begin
        do_create(pick_need());
        if ($urandom_range(0, 4) == 0) do_tick();
      end
      drain_table();
      if ($urandom_range(0, 2) == 0) do_tick();
    end else if (pick < 9) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1)) do_create(pick_need());
        else do_tick();
      end
    end else begin
      repeat ($urandom_range(2, 8)) do_create(pick_need());
      repeat ($urandom_range(1, 4)) do_tick();
    end
  endtask

  // Result side: random stalls, plus long hold-offs to back up the block
  initial begin : result_sink
    int stall;
    int got_n;
    got_n = 0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      if (got_n == 60 || got_n == 300) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sched.check_result(out_data_o);
      got_n++;
      if (got_n % 25 == 0) recv_idle_on = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int base;
    sched       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_POLICY_MODE;
    cfg_data_i  = 5'd0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty tick, a long need, zero need, waiting starts, full table
    do_tick();
    do_create(7'd99);
    do_create(7'd0);
    do_create(7'd1);
    do_create(7'd28);
    repeat (12) do_create(7'($urandom_range(1, 3)));
    do_create(7'd5);
    repeat (5) do_tick();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      stop_input();
      settle();
      write_reg(CFG_POLICY_MODE, 5'(PolicyPlan[ph]));
      write_reg(CFG_READY_LIMIT, LimitPlan[ph]);
      n_settings++;
      base = sched.n_create + sched.n_tick;
      while (sched.n_create + sched.n_tick - base < PhaseItems) run_sequence();
    end

    stop_input();
    settle();
    repeat (2 * SLOTS + 10) @(posedge clk_i);

    $display("Checked %0d results: %0d creates (%0d refused, %0d placed waiting), %0d ticks",
             sched.n_checked, sched.n_create, sched.n_refused, sched.n_waiting, sched.n_tick);
    $display("%0d completions, %0d table clears, %0d priority switches, %0d register settings",
             sched.n_finished, sched.n_cleared, sched.n_switch, n_settings);
    if (sched.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
